// File: sv/lennard_jones_pair_force_core_assert.svh
// Assertion macros used by the checker of the Lennard-Jones pair force core.
`ifndef LENNARD_JONES_PAIR_FORCE_CORE_ASSERT_SVH
`define LENNARD_JONES_PAIR_FORCE_CORE_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define LJPF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define LJPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/ljpf_pkg.sv
// Shared types, register indexes and helper functions of the Lennard-Jones pair force core.
package ljpf_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PBC_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z      = 3'd4;

  // Reset value of the squared cutoff: 144.0 in Q32.16.
  localparam logic [47:0] CUTOFF_SQ_RESET = 48'd9437184;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_WRAP,
    S_RSQ,
    S_CUT,
    S_EPS_MUL,
    S_SQRT,
    S_RM_MUL,
    S_S_DIV,
    S_S2_MUL,
    S_L6_MUL,
    S_L12_MUL,
    S_EA_MUL,
    S_EB_MUL,
    S_ENERGY,
    S_NUM_MUL,
    S_K_DIV,
    S_F_MUL,
    S_TOTAL,
    S_OUT
  } ljpf_state_t;

  // Signed 48-bit value from a magnitude and a sign, saturated.
  function automatic logic signed [47:0] sat_signed48(input logic [63:0] mag, input logic neg);
    logic [63:0] negated;
    negated = ~mag + 64'd1;
    if (neg) begin
      if (mag >= 64'h0000_8000_0000_0000) return 48'sh8000_0000_0000;
      return negated[47:0];
    end
    if (mag >= 64'h0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    return mag[47:0];
  endfunction

  // Upper part of a 128-bit product shifted right by 32, saturated to 64 bits.
  function automatic logic [63:0] sat_shr32(input logic [127:0] prod);
    if (|prod[127:96]) return '1;
    return prod[95:32];
  endfunction

endpackage

// File: sv/ljpf_mul.sv
// Shared 64 by 64 multiplier built from one 32 by 32 multiplier over four partial products.
module ljpf_mul import ljpf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [1:0]   ph;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_sel;
  logic         pp_v;
  logic         done_r;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_shifted;

  // Select the halves for the current partial product.
  assign a_half = ph[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = ph[0] ? b_r[63:32] : b_r[31:0];

  // Align the registered partial product.
  always_comb begin
    case (pp_sel)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd3:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {32'd0, pp, 32'd0};
    endcase
  end

  // Control of the issue and accumulate steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ph     <= 2'd0;
      pp_v   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pp_v   <= busy;
      done_r <= pp_v && (pp_sel == 2'd3);
      if (start) begin
        busy <= 1'b1;
        ph   <= 2'd0;
      end else if (busy) begin
        ph <= ph + 2'd1;
        if (ph == 2'd3) busy <= 1'b0;
      end
    end
  end

  // Operand latch, multiplier and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (pp_v) begin
      prod <= prod + pp_shifted;
    end
    if (busy) begin
      pp     <= 64'(a_half) * 64'(b_half);
      pp_sel <= ph;
    end
  end

  assign done = done_r;

endmodule

// File: sv/ljpf_div.sv
// Restoring divider: 128-bit dividend over a 64-bit divisor, one quotient bit per cycle.
module ljpf_div import ljpf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [63:0]  quo,
  output logic [63:0]  rem
);

  logic [63:0] den_r;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_r;
  logic [65:0] trial;
  logic        ge;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {1'b0, rem, quo[63]} - {2'd0, den_r};
  assign ge    = ~trial[65];

  // Iteration control; a quotient that would overflow saturates at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= 6'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt <= 6'd0;
        if (num[127:64] >= den) done_r <= 1'b1;
        else busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= num[127:64];
      quo   <= (num[127:64] >= den) ? '1 : num[63:0];
    end else if (busy) begin
      rem <= ge ? trial[63:0] : {rem[62:0], quo[63]};
      quo <= {quo[62:0], ge};
    end
  end

  assign done = done_r;

endmodule

// File: sv/lennard_jones_pair_force_core.sv
// Lennard-Jones 12-6 pair force and energy core with cutoff, minimum-image wrap and energy sum.
// One atom pair enters per item as Q16.16 displacement, Q8.24 well depths and radii; one
// result leaves per item as Q24.24 saturated force vector, pair energy and running energy sum.
// All arithmetic runs on one shared 32x32 multiplier, one restoring divider and a bit-pair square
// root, stepped by a sequencer that holds s_tready low until its item is finished. Each axis
// that is wrapped when PBC is on adds a divide; a pair outside the cutoff goes from the cutoff
// test straight to the energy sum. The result sits in an output register, so the next item is
// taken while the previous result waits. The energy sum clears after a result whose tlast is
// set. Configuration is to be written by the user only while the core is idle; the core itself
// does not enforce this.
module lennard_jones_pair_force_core import ljpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // dx, dy, dz, eps_i, eps_j, radius_i, radius_j, 32 bits each from bit 0 up
  input  logic [223:0]         s_tdata,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // force_x, force_y, force_z, pair_energy, energy_total, 48 bits each from bit 0 up
  output logic [239:0]         m_tdata,
  // in_range
  output logic                 m_tuser,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data
);

  ljpf_state_t state, state_next;

  // Configuration registers.
  logic [47:0] cutoff_sq;
  logic        pbc_enable;
  logic [30:0] box_x;
  logic [30:0] box_y;
  logic [30:0] box_z;

  // Item registers.
  logic signed [31:0] dv [3];
  logic [31:0]        eps_i;
  logic [31:0]        eps_j;
  logic [31:0]        radius_i;
  logic [31:0]        radius_j;
  logic               last_pair;
  logic [1:0]         ax;

  // Working registers.
  logic [63:0]        rsq;
  logic               inr;
  logic [63:0]        sq_v;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [63:0]        s_val;
  logic [63:0]        s2;
  logic [63:0]        l6;
  logic [63:0]        l12;
  logic [127:0]       ea;
  logic [128:0]       ediff;
  logic signed [47:0] energy;
  logic               cneg;
  logic [63:0]        dmag;
  logic [63:0]        k;
  logic signed [47:0] f [3];
  logic signed [47:0] total;
  logic signed [47:0] energy_accumulator;
  logic               launched;
  logic               launched_next;

  // Shared unit connections.
  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_done;
  logic [127:0] mul_prod;
  logic         div_start;
  logic [127:0] div_num;
  logic [63:0]  div_den;
  logic         div_done;
  logic [63:0]  div_quo;
  logic [63:0]  div_rem;
  logic         sq_start;

  // Derived values.
  logic               s_accept;
  logic               out_load;
  logic signed [31:0] cur_d;
  logic [31:0]        cur_mag;
  logic [30:0]        cur_box;
  logic               wrap_need;
  logic [30:0]        r0;
  logic [30:0]        r1;
  logic [31:0]        wrapped;
  logic               inr_calc;
  logic [32:0]        rsum;
  logic [40:0]        rm8;
  logic [31:0]        eps;
  logic [43:0]        eps12;
  logic [63:0]        sq_try;
  logic [127:0]       emag128;
  logic [63:0]        fm;
  logic [48:0]        sum49;
  logic signed [47:0] total_sat;
  logic               is_mul_state;

  ljpf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ljpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign s_accept  = s_tvalid && s_tready;
  assign out_load  = (state == S_OUT) && (!m_tvalid || m_tready);
  assign cfg_ready = 1'b1;

  // Axis selected by the axis counter.
  assign cur_d   = dv[ax];
  assign cur_mag = cur_d[31] ? (~cur_d + 32'd1) : cur_d;
  always_comb begin
    case (ax)
      2'd0:    cur_box = box_x;
      2'd1:    cur_box = box_y;
      default: cur_box = box_z;
    endcase
  end
  assign wrap_need = pbc_enable && (cur_box != 31'd0);

  // Minimum image: floor remainder placed in (-L/2, L/2].
  assign r0 = div_rem[30:0];
  assign r1 = (cur_d[31] && (r0 != 31'd0)) ? (cur_box - r0) : r0;
  assign wrapped = ({r1, 1'b0} > {1'b0, cur_box}) ? ({1'b0, r1} - {1'b0, cur_box})
                                                    : {1'b0, r1};

  // Exact cutoff test of the Q32.32 squared distance against the Q32.16 squared limit.
  assign inr_calc = rsq <= {cutoff_sq, 16'd0};

  // Combined radius and depth terms.
  assign rsum  = {1'b0, radius_i} + {1'b0, radius_j};
  assign rm8   = {rsum, 8'd0};
  assign eps   = sq_res[31:0];
  assign eps12 = {1'b0, eps, 11'd0} + {2'd0, eps, 10'd0};

  // Square root step.
  assign sq_try = sq_res + sq_bit;

  // Energy magnitude and force magnitude.
  assign emag128 = ediff[128] ? (~ediff[127:0] + 128'd1) : ediff[127:0];
  assign fm      = (|mul_prod[127:88]) ? '1 : mul_prod[87:24];

  // Saturating running sum.
  assign sum49 = {energy_accumulator[47], energy_accumulator} + {energy[47], energy};
  always_comb begin
    if (sum49[48] != sum49[47]) total_sat = sum49[48] ? 48'sh8000_0000_0000
                                                      : 48'sh7FFF_FFFF_FFFF;
    else total_sat = sum49[47:0];
  end

  // Multiplier operands by step.
  always_comb begin
    is_mul_state = 1'b1;
    case (state)
      S_RSQ: begin
        mul_a = {32'd0, cur_mag};
        mul_b = {32'd0, cur_mag};
      end
      S_EPS_MUL: begin
        mul_a = {32'd0, eps_i};
        mul_b = {32'd0, eps_j};
      end
      S_RM_MUL: begin
        mul_a = {23'd0, rm8};
        mul_b = {23'd0, rm8};
      end
      S_S2_MUL: begin
        mul_a = s_val;
        mul_b = s_val;
      end
      S_L6_MUL: begin
        mul_a = s2;
        mul_b = s_val;
      end
      S_L12_MUL: begin
        mul_a = l6;
        mul_b = l6;
      end
      S_EA_MUL: begin
        mul_a = {32'd0, eps};
        mul_b = l12;
      end
      S_EB_MUL: begin
        mul_a = {31'd0, eps, 1'b0};
        mul_b = l6;
      end
      S_NUM_MUL: begin
        mul_a = {20'd0, eps12};
        mul_b = dmag;
      end
      S_F_MUL: begin
        mul_a = k;
        mul_b = {32'd0, cur_mag};
      end
      default: begin
        mul_a        = '0;
        mul_b        = '0;
        is_mul_state = 1'b0;
      end
    endcase
  end

  // Divider operands by step.
  always_comb begin
    if (state == S_WRAP) begin
      div_num = {96'd0, cur_mag};
      div_den = {33'd0, cur_box};
    end else begin
      div_num = mul_prod;
      div_den = rsq;
    end
  end

  // Unit launch strobes, one per visit of a step, or one per axis in the axis steps.
  always_comb begin
    mul_start = !launched && is_mul_state;
    div_start = !launched && ((state == S_S_DIV) || (state == S_K_DIV) ||
                              ((state == S_WRAP) && wrap_need));
    sq_start  = !launched && (state == S_SQRT);
    s_tready  = (state == S_IDLE);
    if ((state_next != state) || mul_done || div_done) launched_next = 1'b0;
    else launched_next = launched || mul_start || div_start || sq_start;
  end

  // Next step of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_accept) state_next = S_WRAP;
      S_WRAP:    if ((!wrap_need || div_done) && (ax == 2'd2)) state_next = S_RSQ;
      S_RSQ:     if (mul_done && (ax == 2'd2)) state_next = S_CUT;
      S_CUT:     state_next = inr_calc ? S_EPS_MUL : S_TOTAL;
      S_EPS_MUL: if (mul_done) state_next = S_SQRT;
      S_SQRT:    if (launched && sq_bit[0]) state_next = S_RM_MUL;
      S_RM_MUL:  if (mul_done) state_next = (rsq == 64'd0) ? S_S2_MUL : S_S_DIV;
      S_S_DIV:   if (div_done) state_next = S_S2_MUL;
      S_S2_MUL:  if (mul_done) state_next = S_L6_MUL;
      S_L6_MUL:  if (mul_done) state_next = S_L12_MUL;
      S_L12_MUL: if (mul_done) state_next = S_EA_MUL;
      S_EA_MUL:  if (mul_done) state_next = S_EB_MUL;
      S_EB_MUL:  if (mul_done) state_next = S_ENERGY;
      S_ENERGY:  state_next = S_NUM_MUL;
      S_NUM_MUL: if (mul_done) state_next = (rsq == 64'd0) ? S_TOTAL : S_K_DIV;
      S_K_DIV:   if (div_done) state_next = S_F_MUL;
      S_F_MUL:   if (mul_done && (ax == 2'd2)) state_next = S_TOTAL;
      S_TOTAL:   state_next = S_OUT;
      S_OUT:     if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control state, configuration and the energy sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      launched           <= 1'b0;
      ax                 <= 2'd0;
      m_tvalid           <= 1'b0;
      energy_accumulator <= '0;
      cutoff_sq          <= CUTOFF_SQ_RESET;
      pbc_enable         <= 1'b0;
      box_x              <= '0;
      box_y              <= '0;
      box_z              <= '0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
      if (s_accept) ax <= 2'd0;
      else if (((state == S_WRAP) && (!wrap_need || div_done)) ||
               (((state == S_RSQ) || (state == S_F_MUL)) && mul_done)) begin
        ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (state == S_TOTAL) energy_accumulator <= last_pair ? '0 : total_sat;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUTOFF_SQ:  cutoff_sq  <= cfg_data;
          REG_PBC_ENABLE: pbc_enable <= cfg_data[0];
          REG_BOX_X:      box_x      <= cfg_data[30:0];
          REG_BOX_Y:      box_y      <= cfg_data[30:0];
          REG_BOX_Z:      box_z      <= cfg_data[30:0];
          default:        ;
        endcase
      end
    end
  end

  // Datapath registers, written step by step.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          dv[0]     <= s_tdata[31:0];
          dv[1]     <= s_tdata[63:32];
          dv[2]     <= s_tdata[95:64];
          eps_i     <= s_tdata[127:96];
          eps_j     <= s_tdata[159:128];
          radius_i  <= s_tdata[191:160];
          radius_j  <= s_tdata[223:192];
          last_pair <= s_tlast;
          rsq       <= '0;
          energy    <= '0;
          f[0]      <= '0;
          f[1]      <= '0;
          f[2]      <= '0;
        end
      end
      S_WRAP: if (wrap_need && div_done) dv[ax] <= wrapped;
      S_RSQ: if (mul_done) rsq <= rsq + mul_prod[63:0];
      S_CUT: inr <= inr_calc;
      S_SQRT: begin
        if (sq_start) begin
          sq_v   <= mul_prod[63:0];
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
        end else begin
          if (sq_v >= sq_try) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      S_RM_MUL: if (mul_done && (rsq == 64'd0)) s_val <= (rm8 != 41'd0) ? '1 : '0;
      S_S_DIV: if (div_done) s_val <= div_quo;
      S_S2_MUL: if (mul_done) s2 <= sat_shr32(mul_prod);
      S_L6_MUL: if (mul_done) l6 <= sat_shr32(mul_prod);
      S_L12_MUL: if (mul_done) l12 <= sat_shr32(mul_prod);
      S_EA_MUL: if (mul_done) ea <= mul_prod;
      S_EB_MUL: if (mul_done) ediff <= {1'b0, ea} - {1'b0, mul_prod};
      S_ENERGY: begin
        energy <= sat_signed48(sat_shr32(emag128), ediff[128]);
        cneg   <= l12 < l6;
        dmag   <= (l12 < l6) ? (l6 - l12) : (l12 - l6);
      end
      S_K_DIV: if (div_done) k <= div_quo;
      S_F_MUL: if (mul_done) f[ax] <= sat_signed48(fm, cneg ^ cur_d[31]);
      S_TOTAL: total <= total_sat;
      S_OUT: begin
        if (out_load) begin
          m_tdata <= {total, energy, f[2], f[1], f[0]};
          m_tuser <= inr;
          m_tlast <= last_pair;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/ljpf_checker.sv
// Port-level checker of the Lennard-Jones pair force core and its bind.
`include "lennard_jones_pair_force_core_assert.svh"
module ljpf_checker import ljpf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [223:0]         s_tdata,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [239:0]         m_tdata,
  input logic                 m_tuser,
  input logic                 m_tlast,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [47:0]          cfg_data
);

  // A stalled result item holds its contents.
  `LJPF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result item changed while stalled")

  // The core is busy right after it takes an item.
  `LJPF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "core ready right after accepting an item")

  // A pair outside the cutoff carries no force and no energy.
  `LJPF_ASSERT_SAME(a_out_of_range_zero, m_tvalid && !m_tuser, m_tdata[191:0] == 192'd0, "nonzero force or energy for a pair outside the cutoff")

endmodule

bind lennard_jones_pair_force_core ljpf_checker u_ljpf_checker (.*);
